// ===== rtl/msp_fr_pkg.sv =====
// Shared constants and types for the MSP v1 frame receiver.
package msp_fr_pkg;

  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_REQUEST  = 8'h3C;
  localparam logic [7:0] CH_RESPONSE = 8'h3E;
  localparam logic [7:0] CH_ERROR    = 8'h21;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_END_GOOD = 2'd1;
  localparam logic [1:0] KIND_END_BAD  = 2'd2;

  localparam logic [1:0] DIR_REQUEST  = 2'd0;
  localparam logic [1:0] DIR_RESPONSE = 2'd1;
  localparam logic [1:0] DIR_ERROR    = 2'd2;

  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic [7:0] frame_command;
    logic [1:0] frame_direction;
    logic [7:0] frame_size;
  } msp_fr_result_t;

endpackage

// ===== rtl/msp_fr_parser.sv =====
// Frame parsing state machine: consumes one byte per step and yields at most one result.
module msp_fr_parser
  import msp_fr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  output msp_fr_result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DOLLAR   = 3'd1,
    PH_M        = 3'd2,
    PH_SIZE     = 3'd3,
    PH_COMMAND  = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_CHECKSUM = 3'd6
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] direction_r, direction_nxt;
  logic [7:0] size_r, size_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] count_inc;

  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    direction_nxt = direction_r;
    size_nxt      = size_r;
    count_nxt     = count_r;
    command_nxt   = command_r;
    xor_nxt       = xor_r;
    res                 = '0;
    res.frame_command   = command_r;
    res.frame_direction = direction_r;
    res.frame_size      = size_r;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CH_DOLLAR) begin
          phase_nxt = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        phase_nxt = (rx_byte == CH_M) ? PH_M : PH_IDLE;
      end
      PH_M: begin
        if (rx_byte == CH_REQUEST || rx_byte == CH_RESPONSE || rx_byte == CH_ERROR) begin
          direction_nxt = (rx_byte == CH_REQUEST)  ? DIR_REQUEST :
                          (rx_byte == CH_RESPONSE) ? DIR_RESPONSE : DIR_ERROR;
          xor_nxt       = 8'd0;
          phase_nxt     = PH_SIZE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_SIZE: begin
        size_nxt  = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        count_nxt = 8'd0;
        phase_nxt = PH_COMMAND;
      end
      PH_COMMAND: begin
        command_nxt = rx_byte;
        xor_nxt     = xor_r ^ rx_byte;
        phase_nxt   = (size_r != 8'd0) ? PH_PAYLOAD : PH_CHECKSUM;
      end
      PH_PAYLOAD: begin
        res.valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = rx_byte;
        res.position  = count_r;
        xor_nxt       = xor_r ^ rx_byte;
        count_nxt     = count_inc;
        if (count_inc >= size_r) begin
          phase_nxt = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        res.valid = 1'b1;
        res.kind  = (xor_r == rx_byte) ? KIND_END_GOOD : KIND_END_BAD;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt     = PH_IDLE;
        direction_nxt = 2'd0;
        size_nxt      = 8'd0;
        count_nxt     = 8'd0;
        command_nxt   = 8'd0;
        xor_nxt       = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      direction_r <= 2'd0;
      size_r      <= 8'd0;
      count_r     <= 8'd0;
      command_r   <= 8'd0;
      xor_r       <= 8'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      direction_r <= direction_nxt;
      size_r      <= size_nxt;
      count_r     <= count_nxt;
      command_r   <= command_nxt;
      xor_r       <= xor_nxt;
    end
  end

`ifndef SYNTH
  a_payload_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> size_r != 8'd0)
    else $error("payload phase entered with zero size");

  a_payload_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> count_r < size_r)
    else $error("payload count reached announced size");

  a_checksum_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_CHECKSUM |=> phase_r == PH_IDLE)
    else $error("parser did not return to idle after frame end");
`endif

endmodule

// ===== rtl/msp_v1_frame_receiver_unit.sv =====
// Top level of the MSP v1 frame receiver with input and result registers.
//
// The block takes one received serial byte per item on the in_ stream and
// recognises MSP v1 frames ('$', 'M', direction, size, command, payload,
// XOR checksum). Each payload byte leaves on the out_ stream with its index
// in the payload; the checksum byte yields one frame-end item marked good or
// bad. Header bytes and stray bytes yield no item.
// An accepted byte sits in an input register while the parser decides its
// result, which is then held in the result register; a full result register
// keeps the byte waiting in the input register.
// One byte can be accepted every cycle while out_tready is high; the single parser
// state update per byte sets that rate. in_tready stays high while the result
// register is free or being emptied, so a stalled receiver holds at most one
// result and one pending byte before in_tready falls.
// Synchronous reset empties both registers and returns the parser to idle
// with all frame fields cleared.
module msp_v1_frame_receiver_unit
  import msp_fr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // rx_byte[7:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_byte, position, frame_command,
                                             // frame_direction, frame_size, zero pad
  output logic [1:0]             out_tuser   // kind[1:0]
);

  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           step;
  msp_fr_result_t res;
  msp_fr_result_t out_r;
  logic           out_valid_r;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  msp_fr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {6'd0, out_r.frame_size, out_r.frame_direction,
                       out_r.frame_command, out_r.position, out_r.data_byte};

`ifndef SYNTH
  a_pending_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(in_byte_r))
    else $error("pending byte lost while result register was full");

  a_frame_end_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind != KIND_PAYLOAD |->
      out_r.data_byte == 8'd0 && out_r.position == 8'd0)
    else $error("frame-end item carries payload data");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.kind == KIND_PAYLOAD || out_r.kind == KIND_END_GOOD ||
                    out_r.kind == KIND_END_BAD)
    else $error("result item with unused kind code");
`endif

endmodule
